// ===== hw/rtl/mpst_pkg.sv =====
// Shared types, codes and defaults for the mailbox pool with soft timers.
`timescale 1ns / 1ps
package mpst_pkg;

  localparam int TASKS_DEF  = 8;
  localparam int SLOTS_DEF  = 16;
  localparam int TIMERS_DEF = 8;

  localparam logic [1:0] KIND_SEND  = 2'd0;
  localparam logic [1:0] KIND_RECV  = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;
  localparam logic [1:0] KIND_START = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NO_TASK = 3'd1;
  localparam logic [2:0] ST_BAD_ID  = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  task_req;
    logic [7:0]  message_id;
    logic [31:0] message_param;
    logic [31:0] period;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  got_id;
    logic [31:0] got_param;
    logic [3:0]  fired;
    logic [3:0]  dropped;
  } out_word_t;

  typedef struct packed {
    logic       load_item;
    logic       res_clr;
    logic       set_status;
    logic [2:0] status_code;
    logic       idx_clr;
    logic       idx_inc;
    logic       tidx_clr;
    logic       tidx_inc;
    logic       tick_inc;
    logic       link_wr;
    logic       slot_alloc;
    logic       rx_pop;
    logic       tmr_wr;
    logic       tmr_fire;
    logic       drop_inc;
    logic       out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       task_ok;
    logic       id_zero;
    logic       mbox_empty;
    logic       slot_busy;
    logic       slot_last;
    logic       tmr_active;
    logic       tmr_last;
    logic       tmr_due;
    logic       out_busy;
  } dp_sts_t;

endpackage

// ===== hw/rtl/mpst_dp.sv =====
// Datapath: slot pool, mailbox lists, timer table, tick counter and result word.
`timescale 1ns / 1ps
module mpst_dp #(
  parameter int TASKS  = mpst_pkg::TASKS_DEF,
  parameter int SLOTS  = mpst_pkg::SLOTS_DEF,
  parameter int TIMERS = mpst_pkg::TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  mpst_pkg::in_word_t  in_data,
  input  mpst_pkg::ctl_cmd_t  cmd,
  input  logic                cfg_we,
  input  logic [3:0]          cfg_wdata,
  output logic [3:0]          tasks_in_use,
  output mpst_pkg::dp_sts_t   sts,
  output logic                out_valid,
  input  logic                out_ready,
  output mpst_pkg::out_word_t out_data
);

  localparam int TW = (TASKS > 1) ? $clog2(TASKS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int XW = (TIMERS > 1) ? $clog2(TIMERS) : 1;

  mpst_pkg::in_word_t  item_r;
  mpst_pkg::out_word_t res_r, out_r;
  logic                out_valid_r;
  logic [3:0]          tasks_r;
  logic [31:0]         tick_r;
  logic [SW-1:0]       idx_r;
  logic [XW-1:0]       tix_r;
  logic [SLOTS-1:0]    busy_r;
  logic [TIMERS-1:0]   active_r;
  logic [TASKS-1:0]    nonempty_r;
  logic [SW-1:0]       head_r [TASKS];
  logic [SW-1:0]       tail_r [TASKS];

  logic [7:0]  slot_id_mem    [SLOTS];
  logic [31:0] slot_param_mem [SLOTS];
  logic [SW:0] slot_link_mem  [SLOTS];
  logic [7:0]  sid_rd_r;
  logic [31:0] spar_rd_r;
  logic [SW:0] slink_rd_r;

  logic [7:0]  tmr_id_mem  [TIMERS];
  logic [2:0]  tmr_own_mem [TIMERS];
  logic [31:0] tmr_per_mem [TIMERS];
  logic [31:0] tmr_dl_mem  [TIMERS];
  logic [7:0]  tid_rd_r;
  logic [2:0]  town_rd_r;
  logic [31:0] tper_rd_r;
  logic [31:0] tdl_rd_r;

  logic          sel_timer;
  logic [2:0]    cur_task;
  logic [7:0]    cur_id;
  logic [31:0]   cur_param;
  logic [TW-1:0] tsel;
  logic [SW-1:0] head_a, tail_a;
  logic [31:0]   dl_gap;

  assign sel_timer = (item_r.kind == mpst_pkg::KIND_TICK);
  assign cur_task  = sel_timer ? town_rd_r : item_r.task_req;
  assign cur_id    = sel_timer ? tid_rd_r : item_r.message_id;
  assign cur_param = sel_timer ? 32'd0 : item_r.message_param;
  assign tsel      = TW'(cur_task);
  assign head_a    = head_r[tsel];
  assign tail_a    = tail_r[tsel];
  assign dl_gap    = tdl_rd_r - tick_r;

  assign sts.kind       = item_r.kind;
  assign sts.task_ok    = ({1'b0, cur_task} < tasks_r) && ({4'b0, cur_task} < 7'(TASKS));
  assign sts.id_zero    = (item_r.message_id == 8'd0);
  assign sts.mbox_empty = !nonempty_r[tsel];
  assign sts.slot_busy  = busy_r[idx_r];
  assign sts.slot_last  = (idx_r == SW'(SLOTS - 1));
  assign sts.tmr_active = active_r[tix_r];
  assign sts.tmr_last   = (tix_r == XW'(TIMERS - 1));
  assign sts.tmr_due    = (dl_gap == 32'd0) || dl_gap[31];
  assign sts.out_busy   = out_valid_r && !out_ready;

  assign tasks_in_use = tasks_r;
  assign out_valid    = out_valid_r;
  assign out_data     = out_r;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tasks_r     <= 4'd0;
      tick_r      <= 32'd0;
      idx_r       <= '0;
      tix_r       <= '0;
      busy_r      <= '0;
      active_r    <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        tasks_r <= cfg_wdata;
      end
      if (cmd.tick_inc) begin
        tick_r <= tick_r + 32'd1;
      end
      if (cmd.idx_clr) begin
        idx_r <= '0;
      end else if (cmd.idx_inc) begin
        idx_r <= idx_r + SW'(1);
      end
      if (cmd.tidx_clr) begin
        tix_r <= '0;
      end else if (cmd.tidx_inc) begin
        tix_r <= tix_r + XW'(1);
      end
      if (cmd.slot_alloc) begin
        busy_r[idx_r]    <= 1'b1;
        nonempty_r[tsel] <= 1'b1;
      end
      if (cmd.rx_pop) begin
        busy_r[head_a] <= 1'b0;
        if (slink_rd_r[SW]) begin
          nonempty_r[tsel] <= 1'b0;
        end
      end
      if (cmd.tmr_wr) begin
        active_r[tix_r] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_r <= in_data;
    end
    if (cmd.slot_alloc) begin
      tail_r[tsel] <= idx_r;
      if (!nonempty_r[tsel]) begin
        head_r[tsel] <= idx_r;
      end
    end
    if (cmd.rx_pop && !slink_rd_r[SW]) begin
      head_r[tsel] <= slink_rd_r[SW-1:0];
    end
    if (cmd.res_clr) begin
      res_r <= '0;
    end else begin
      if (cmd.set_status) begin
        res_r.status <= cmd.status_code;
      end
      if (cmd.rx_pop) begin
        res_r.got_id    <= sid_rd_r;
        res_r.got_param <= spar_rd_r;
      end
      if (cmd.tmr_fire) begin
        res_r.fired <= res_r.fired + 4'd1;
      end
      if (cmd.drop_inc) begin
        res_r.dropped <= res_r.dropped + 4'd1;
      end
    end
    if (cmd.out_load) begin
      out_r <= res_r;
    end
  end

  // slot pool memory
  always_ff @(posedge clk) begin
    if (cmd.slot_alloc) begin
      slot_id_mem[idx_r]    <= cur_id;
      slot_param_mem[idx_r] <= cur_param;
    end
    if (cmd.link_wr) begin
      slot_link_mem[tail_a] <= {1'b0, idx_r};
    end else if (cmd.slot_alloc) begin
      slot_link_mem[idx_r] <= {1'b1, SW'(0)};
    end
    sid_rd_r   <= slot_id_mem[head_a];
    spar_rd_r  <= slot_param_mem[head_a];
    slink_rd_r <= slot_link_mem[head_a];
  end

  // timer table memory
  always_ff @(posedge clk) begin
    if (cmd.tmr_wr) begin
      tmr_id_mem[tix_r]  <= item_r.message_id;
      tmr_own_mem[tix_r] <= item_r.task_req;
      tmr_per_mem[tix_r] <= item_r.period;
      tmr_dl_mem[tix_r]  <= tick_r + item_r.period;
    end else if (cmd.tmr_fire) begin
      tmr_dl_mem[tix_r] <= tdl_rd_r + tper_rd_r;
    end
    tid_rd_r  <= tmr_id_mem[tix_r];
    town_rd_r <= tmr_own_mem[tix_r];
    tper_rd_r <= tmr_per_mem[tix_r];
    tdl_rd_r  <= tmr_dl_mem[tix_r];
  end

endmodule

// ===== hw/rtl/mpst_ctrl.sv =====
// Controller: sequences send, receive, tick scan and timer start over the datapath.
`timescale 1ns / 1ps
module mpst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mpst_pkg::dp_sts_t  sts,
  output mpst_pkg::ctl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SCAN, S_LINK, S_ALLOC, S_RXPOP,
    S_TFREE, S_TCHK, S_TEVAL, S_TNEXT, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          cmd.res_clr   = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        cmd.idx_clr  = 1'b1;
        cmd.tidx_clr = 1'b1;
        unique case (sts.kind)
          mpst_pkg::KIND_SEND: begin
            if (!sts.task_ok) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = mpst_pkg::ST_NO_TASK;
              state_nxt       = S_FIN;
            end else if (sts.id_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = mpst_pkg::ST_BAD_ID;
              state_nxt       = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
          mpst_pkg::KIND_RECV: begin
            if (!sts.task_ok) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = mpst_pkg::ST_NO_TASK;
              state_nxt       = S_FIN;
            end else if (sts.mbox_empty) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = mpst_pkg::ST_EMPTY;
              state_nxt       = S_FIN;
            end else begin
              state_nxt = S_RXPOP;
            end
          end
          mpst_pkg::KIND_TICK: begin
            cmd.tick_inc = 1'b1;
            state_nxt    = S_TCHK;
          end
          default: begin
            if (sts.id_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = mpst_pkg::ST_BAD_ID;
              state_nxt       = S_FIN;
            end else begin
              state_nxt = S_TFREE;
            end
          end
        endcase
      end
      S_SCAN: begin
        if (!sts.slot_busy) begin
          state_nxt = sts.mbox_empty ? S_ALLOC : S_LINK;
        end else if (sts.slot_last) begin
          if (sts.kind == mpst_pkg::KIND_TICK) begin
            cmd.drop_inc = 1'b1;
            state_nxt    = S_TNEXT;
          end else begin
            cmd.set_status  = 1'b1;
            cmd.status_code = mpst_pkg::ST_FULL;
            state_nxt       = S_FIN;
          end
        end else begin
          cmd.idx_inc = 1'b1;
        end
      end
      S_LINK: begin
        cmd.link_wr = 1'b1;
        state_nxt   = S_ALLOC;
      end
      S_ALLOC: begin
        cmd.slot_alloc = 1'b1;
        state_nxt      = (sts.kind == mpst_pkg::KIND_TICK) ? S_TNEXT : S_FIN;
      end
      S_RXPOP: begin
        cmd.rx_pop = 1'b1;
        state_nxt  = S_FIN;
      end
      S_TFREE: begin
        if (!sts.tmr_active) begin
          cmd.tmr_wr = 1'b1;
          state_nxt  = S_FIN;
        end else if (sts.tmr_last) begin
          cmd.set_status  = 1'b1;
          cmd.status_code = mpst_pkg::ST_FULL;
          state_nxt       = S_FIN;
        end else begin
          cmd.tidx_inc = 1'b1;
        end
      end
      S_TCHK: begin
        state_nxt = sts.tmr_active ? S_TEVAL : S_TNEXT;
      end
      S_TEVAL: begin
        if (sts.tmr_due) begin
          cmd.tmr_fire = 1'b1;
          if (sts.task_ok) begin
            cmd.idx_clr = 1'b1;
            state_nxt   = S_SCAN;
          end else begin
            state_nxt = S_TNEXT;
          end
        end else begin
          state_nxt = S_TNEXT;
        end
      end
      S_TNEXT: begin
        if (sts.tmr_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.tidx_inc = 1'b1;
          state_nxt    = S_TCHK;
        end
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== hw/rtl/mailbox_pool_with_soft_timers.sv =====
// Top level: message pool with per-task mailboxes and periodic soft timers.
//
//   channel | ports                       | word
//   --------+-----------------------------+-----------------------------
//   input   | in_valid / in_ready         | in_data  (in_word_t)
//   result  | out_valid / out_ready       | out_data (out_word_t)
//   config  | cfg_psel .. cfg_pready      | tasks_in_use at byte addr 0
//
// One word at a time. Send: linear free-slot scan.
// Start timer: free-timer scan. Tick: one timer checked at a time.
// Synchronous reset empties the pool, mailboxes and timers; tick count is 0.
// A finished word waits in the output register; a new word is taken meanwhile.
`timescale 1ns / 1ps
module mailbox_pool_with_soft_timers #(
  parameter int TASKS  = mpst_pkg::TASKS_DEF,
  parameter int SLOTS  = mpst_pkg::SLOTS_DEF,
  parameter int TIMERS = mpst_pkg::TIMERS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mpst_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output mpst_pkg::out_word_t out_data,
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  mpst_pkg::ctl_cmd_t cmd;
  mpst_pkg::dp_sts_t  sts;
  logic               cfg_we;
  logic [3:0]         tasks_in_use;

  assign cfg_pready = 1'b1;
  assign cfg_we     = cfg_psel && cfg_penable && cfg_pwrite && !cfg_paddr[2];
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {28'd0, tasks_in_use};

  mpst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mpst_dp #(
    .TASKS  (TASKS),
    .SLOTS  (SLOTS),
    .TIMERS (TIMERS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_data      (in_data),
    .cmd          (cmd),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_pwdata[3:0]),
    .tasks_in_use (tasks_in_use),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

endmodule
